### src/slat_pkg.sv
// shared types and constants for the slave link table
package slat_pkg;

   localparam int MAX_SLAVES = 32;
   localparam int IDX_W = (MAX_SLAVES > 1) ? $clog2(MAX_SLAVES) : 1;
   localparam int CNT_W = $clog2(MAX_SLAVES + 1);

   localparam logic [7:0] LEAD_BYTE = 8'h66;

   localparam logic [2:0] CMD_FRAME = 3'd0;
   localparam logic [2:0] CMD_ADD = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_RESET = 3'd3;
   localparam logic [2:0] CMD_DISC = 3'd4;

   localparam logic [1:0] MODE_FREE = 2'd0;
   localparam logic [1:0] MODE_KNOWN = 2'd1;
   localparam logic [1:0] MODE_CONN = 2'd2;

   localparam logic [2:0] IND_NONE = 3'd0;
   localparam logic [2:0] IND_CONNECT = 3'd1;
   localparam logic [2:0] IND_DATA = 3'd2;
   localparam logic [2:0] IND_REQ = 3'd3;
   localparam logic [2:0] IND_SEGREQ = 3'd4;
   localparam logic [2:0] IND_RSP = 3'd5;
   localparam logic [2:0] IND_SEGRSP = 3'd6;
   localparam logic [2:0] IND_DISC = 3'd7;

   localparam logic [2:0] SRC_HDR = 3'd0;
   localparam logic [2:0] SRC_CONNECT = 3'd1;
   localparam logic [2:0] SRC_RETX = 3'd2;
   localparam logic [2:0] SRC_RSP = 3'd3;
   localparam logic [2:0] SRC_REQ = 3'd4;
   localparam logic [2:0] SRC_IO = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan_clr;  // reset scan index
      logic scan_step; // advance scan index
      logic exec;      // apply command
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

### src/slat_ctrl.sv
// controller sequencing the table scan and update
module slat_ctrl
   import slat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               ctl.scan_clr = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_EXEC;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### src/slat_dp.sv
// slave table storage, lookup scan and command execution
module slat_dp
   import slat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  ctl_type    ctl,
   output sts_type    sts,
   input  logic [2:0] cmd,
   input  logic [7:0] frame_lead,
   input  logic [7:0] slave_addr,
   input  logic [7:0] frame_type,
   input  logic [11:0] frame_len,
   input  logic [7:0] payload_kind,
   input  logic       rsp_pend,
   input  logic       req_pend,
   input  logic       io_pend,
   output logic       o_valid,
   output logic       o_accepted,
   output logic [2:0] o_indication,
   output logic       o_clear_io_ack,
   output logic       o_io_refresh,
   output logic       o_reply_valid,
   output logic [2:0] o_reply_type,
   output logic [2:0] o_reply_source,
   output logic       o_table_full
);

   logic [7:0]       addr_ff [MAX_SLAVES];
   logic [1:0]       mode_ff [MAX_SLAVES];
   logic [MAX_SLAVES-1:0] tx_ff, rx_ff;
   logic [2:0]       retry_ff [MAX_SLAVES];
   logic [CNT_W-1:0] used_ff;

   logic [2:0]  cmd_ff;
   logic [7:0]  lead_ff, sa_ff, ft_ff, kind_ff;
   logic [11:0] len_ff;
   logic        rsp_ff, req_ff, io_ff;

   logic [CNT_W-1:0] scan_ff;
   logic             hit_ff, free_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff;

   logic [IDX_W-1:0] sidx;
   assign sidx = scan_ff[IDX_W-1:0];
   logic scan_end;
   assign scan_end = (scan_ff >= used_ff) || (scan_ff == CNT_W'(MAX_SLAVES));
   assign sts.scan_done = scan_end || hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= cmd; lead_ff <= frame_lead; sa_ff <= slave_addr;
         ft_ff <= frame_type; len_ff <= frame_len; kind_ff <= payload_kind;
         rsp_ff <= rsp_pend; req_ff <= req_pend; io_ff <= io_pend;
      end
      if (ctl.scan_clr) begin
         scan_ff <= '0; hit_ff <= 1'b0; free_ff <= 1'b0;
      end else if (ctl.scan_step) begin
         scan_ff <= scan_ff + 1'b1;
         if (mode_ff[sidx] != MODE_FREE && addr_ff[sidx] == sa_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= sidx;
         end
         if (mode_ff[sidx] == MODE_FREE && !free_ff) begin
            free_ff <= 1'b1;
            free_idx_ff <= sidx;
         end
      end
   end

   // frame execution values
   logic [1:0] hmode;
   logic       htx, hrx, ntx, nrx, ack_clr, dup;
   logic [2:0] hretry, r1, nretry, ind, src;
   logic       type_ok, frame_ok, is_conn;
   logic [11:0] plen;

   always_comb begin
      hmode = mode_ff[hit_idx_ff];
      htx = tx_ff[hit_idx_ff];
      hrx = rx_ff[hit_idx_ff];
      hretry = retry_ff[hit_idx_ff];
      is_conn = (ft_ff < 8'd2);
      type_ok = is_conn || (ft_ff > 8'd3 && ft_ff < 8'd8);
      frame_ok = (len_ff >= 12'd3) && (lead_ff == LEAD_BYTE) && type_ok && hit_ff &&
                 !((hmode == MODE_KNOWN) && !is_conn) &&
                 !((hmode > MODE_KNOWN) && is_conn);
      dup = (hrx != ft_ff[1]);
      nrx = dup ? hrx : ~hrx;
      ntx = htx;
      r1 = hretry;
      ack_clr = 1'b0;
      if (htx == ft_ff[0]) begin
         if (hretry != 3'd0) begin
            r1 = 3'd0;
            ack_clr = 1'b1;
         end
      end else if (hretry > 3'd2) begin
         ntx = ~htx;
         r1 = 3'd0;
      end
      plen = len_ff - 12'd3;
      ind = IND_NONE;
      if (!dup && plen != 12'd0) begin
         if (plen < 12'd3) ind = IND_DATA;
         else if (kind_ff[0]) ind = (kind_ff == 8'd1) ? IND_REQ : IND_SEGREQ;
         else ind = (kind_ff == 8'd2) ? IND_RSP : IND_SEGRSP;
      end
      nretry = r1;
      if (r1 != 3'd0) begin
         if (r1 < 3'd7) nretry = r1 + 3'd1;
         src = SRC_RETX;
      end else begin
         src = rsp_ff ? SRC_RSP : req_ff ? SRC_REQ : io_ff ? SRC_IO : SRC_HDR;
         if (src != SRC_HDR) begin
            ntx = ~ntx;
            nretry = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         tx_ff <= '0;
         rx_ff <= '0;
         o_valid <= 1'b0;
         for (int k = 0; k < MAX_SLAVES; k++) begin
            mode_ff[k] <= MODE_FREE;
            retry_ff[k] <= 3'd0;
         end
      end else begin
         o_valid <= ctl.exec;
         if (ctl.exec) begin
            o_accepted <= 1'b0; o_indication <= IND_NONE; o_clear_io_ack <= 1'b0;
            o_io_refresh <= 1'b0; o_reply_valid <= 1'b0; o_reply_type <= 3'd0;
            o_reply_source <= SRC_HDR; o_table_full <= 1'b0;
            case (cmd_ff)
               CMD_FRAME: begin
                  if (frame_ok) begin
                     o_accepted <= 1'b1;
                     o_reply_valid <= 1'b1;
                     if (is_conn) begin
                        tx_ff[hit_idx_ff] <= 1'b0;
                        rx_ff[hit_idx_ff] <= 1'b1;
                        retry_ff[hit_idx_ff] <= 3'd0;
                        mode_ff[hit_idx_ff] <= MODE_CONN;
                        o_indication <= IND_CONNECT;
                        o_io_refresh <= 1'b1;
                        o_reply_source <= SRC_CONNECT;
                     end else begin
                        tx_ff[hit_idx_ff] <= ntx;
                        rx_ff[hit_idx_ff] <= nrx;
                        retry_ff[hit_idx_ff] <= nretry;
                        o_indication <= ind;
                        o_clear_io_ack <= ack_clr;
                        o_reply_source <= src;
                        o_reply_type <= {1'b1, ntx, ~nrx};
                     end
                  end
               end
               CMD_ADD: begin
                  if (!hit_ff) begin
                     if (free_ff) begin
                        addr_ff[free_idx_ff] <= sa_ff;
                        mode_ff[free_idx_ff] <= MODE_KNOWN;
                        tx_ff[free_idx_ff] <= 1'b0;
                        retry_ff[free_idx_ff] <= 3'd0;
                        o_accepted <= 1'b1;
                     end else if (used_ff >= CNT_W'(MAX_SLAVES)) begin
                        o_table_full <= 1'b1;
                     end else begin
                        addr_ff[used_ff[IDX_W-1:0]] <= sa_ff;
                        mode_ff[used_ff[IDX_W-1:0]] <= MODE_KNOWN;
                        tx_ff[used_ff[IDX_W-1:0]] <= 1'b0;
                        retry_ff[used_ff[IDX_W-1:0]] <= 3'd0;
                        used_ff <= used_ff + 1'b1;
                        o_accepted <= 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (hit_ff) begin
                     mode_ff[hit_idx_ff] <= MODE_FREE;
                     if (CNT_W'(hit_idx_ff) + 1'b1 == used_ff) used_ff <= used_ff - 1'b1;
                     o_accepted <= 1'b1;
                  end
               end
               CMD_RESET: begin
                  used_ff <= '0;
                  o_accepted <= 1'b1;
               end
               CMD_DISC: begin
                  if (hit_ff) begin
                     if (hmode >= MODE_CONN) begin
                        mode_ff[hit_idx_ff] <= MODE_KNOWN;
                        o_indication <= IND_DISC;
                     end
                     retry_ff[hit_idx_ff] <= 3'd0;
                     tx_ff[hit_idx_ff] <= 1'b0;
                     o_accepted <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

### src/slave_link_arq_table.sv
// top level of the stop-and-wait slave link table
//  channel | ports        | handshake
//  request | req_*, start | start and not busy
//  result  | rsp_*        | rsp_strobe, one cycle
// the linear table scan runs at one slot per cycle and stops at the first address
// match; no new request is taken while busy.
// synchronous reset clears modes, sequence bits, retry counts and fill count;
// stored addresses are not cleared. results cannot be stalled.
module slave_link_arq_table
   import slat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_frame_lead,
   input  logic [7:0]  req_slave_addr,
   input  logic [7:0]  req_frame_type,
   input  logic [11:0] req_frame_len,
   input  logic [7:0]  req_payload_kind,
   input  logic        req_rsp_pending,
   input  logic        req_req_pending,
   input  logic        req_io_pending,
   output logic        rsp_strobe,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_indication,
   output logic        rsp_clear_io_ack,
   output logic        rsp_io_refresh,
   output logic        rsp_reply_valid,
   output logic [2:0]  rsp_reply_type,
   output logic [2:0]  rsp_reply_source,
   output logic        rsp_table_full
);

   ctl_type ctl;
   sts_type sts;
   logic    busy_c;

   slat_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy_c), .sts(sts), .ctl(ctl)
   );

   slat_dp u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .cmd(req_cmd), .frame_lead(req_frame_lead), .slave_addr(req_slave_addr),
      .frame_type(req_frame_type), .frame_len(req_frame_len),
      .payload_kind(req_payload_kind), .rsp_pend(req_rsp_pending),
      .req_pend(req_req_pending), .io_pend(req_io_pending),
      .o_valid(rsp_strobe), .o_accepted(rsp_accepted), .o_indication(rsp_indication),
      .o_clear_io_ack(rsp_clear_io_ack), .o_io_refresh(rsp_io_refresh),
      .o_reply_valid(rsp_reply_valid), .o_reply_type(rsp_reply_type),
      .o_reply_source(rsp_reply_source), .o_table_full(rsp_table_full)
   );

   assign busy = busy_c;

endmodule

### src/slat_checker.sv
// port-level checks for the slave link table, bound to the top level
module slat_checker
   import slat_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_accepted,
   input logic [2:0] rsp_indication,
   input logic       rsp_reply_valid,
   input logic       rsp_table_full
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double result");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_table_full) |-> (!rsp_accepted && !rsp_reply_valid))
      else $error("table full yet accepted");

   a_ind_needs_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_indication != IND_NONE) |-> rsp_accepted)
      else $error("indication without accept");

endmodule

bind slave_link_arq_table slat_checker u_slat_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_accepted(rsp_accepted),
   .rsp_indication(rsp_indication), .rsp_reply_valid(rsp_reply_valid),
   .rsp_table_full(rsp_table_full)
);
